// ----- hdl/ofe_pkg.sv -----
// Shared types, constants and helpers for the switch frame encoder.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package ofe_pkg;

	localparam int FRAME_BITS = 48;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int TIME_W     = 22;
	localparam int BASE_W     = 16;
	localparam int LONG_W     = 4;
	localparam int SYNC_W     = 6;
	localparam int ID_W       = 16;
	localparam int UNIT_W     = 5;
	localparam int IDX_W      = 2;

	localparam logic [ID_W-1:0]   ID_MAX     = ID_W'(29999);
	localparam logic [UNIT_W-1:0] UNIT_MAX   = UNIT_W'(19);
	localparam logic [7:0]        HDR_BYTE   = 8'h55;
	localparam logic [7:0]        FTR_BYTE   = 8'hFF;

	localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(284);
	localparam logic [LONG_W-1:0] LONG_RST = LONG_W'(2);
	localparam logic [SYNC_W-1:0] SYNC_RST = SYNC_W'(34);

	localparam logic [IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG = 2'd1;
	localparam logic [IDX_W-1:0] REG_SYNC = 2'd2;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

	typedef enum logic [1:0] {
		FAULT_NONE = 2'd0,
		FAULT_ID   = 2'd1,
		FAULT_UNIT = 2'd2
	} fault_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		fault_t                fault;
	} cmd_t;

	// Units come in groups of five; each group starts 16 codes further on.
	function automatic logic [7:0] device_code(input logic [UNIT_W-1:0] unit,
		input logic off);
		logic [7:0] g8;
		begin
			if (unit <= UNIT_W'(5))
				g8 = 8'd0;
			else if (unit <= UNIT_W'(10))
				g8 = 8'd1;
			else if (unit <= UNIT_W'(15))
				g8 = 8'd2;
			else
				g8 = 8'd3;
			device_code = (g8 << 4) + {2'b00, unit, 1'b0} - (g8 * 8'd10) - 8'd1
				+ {7'd0, off};
		end
	endfunction

endpackage

// ----- hdl/ook_switch_frame_encoder_unit.sv -----
// Top level of the switch frame encoder: config registers, front end,
// command queue and pulse emitter. Depends on ofe_pkg, ofe_front, ofe_queue, ofe_back.
`timescale 1ns / 1ps
//
// channel   direction  handshake          payload
// command   in         push / full        device_id, unit_number, turn_off
// pulse     out        empty / pop        high_time, low_time, fault, last
// config    in         wr_en              wr_index, wr_data
//
// A valid command gives 48 pulse pairs, one per cycle from the bit shifter while the output item is popped;
// a rejected command gives one error item.
// Up to two commands wait in the queue while another is shifted out.
// Reset loads the register defaults and empties queue and output register.
// The shifter stalls only while the output item is not popped.

module ook_switch_frame_encoder_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [ofe_pkg::ID_W-1:0]     device_id,
	input  logic [ofe_pkg::UNIT_W-1:0]   unit_number,
	input  logic                         turn_off,
	output logic                         empty,
	input  logic                         pop,
	output logic [ofe_pkg::TIME_W-1:0]   high_time,
	output logic [ofe_pkg::TIME_W-1:0]   low_time,
	output logic [1:0]                   fault,
	output logic                         last,
	input  logic                         wr_en,
	input  logic [ofe_pkg::IDX_W-1:0]    wr_index,
	input  logic [ofe_pkg::BASE_W-1:0]   wr_data
);

	logic [ofe_pkg::BASE_W-1:0] base_q;
	logic [ofe_pkg::LONG_W-1:0] long_q;
	logic [ofe_pkg::SYNC_W-1:0] sync_q;

	ofe_pkg::cmd_t new_cmd;
	ofe_pkg::cmd_t head_cmd;
	logic          q_wr;
	logic          q_rd;
	logic          q_full;
	logic          q_empty;
	logic          out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ofe_pkg::BASE_RST;
			long_q <= ofe_pkg::LONG_RST;
			sync_q <= ofe_pkg::SYNC_RST;
		end else if (wr_en) begin
			case (wr_index)
				ofe_pkg::REG_BASE: base_q <= wr_data;
				ofe_pkg::REG_LONG: long_q <= wr_data[ofe_pkg::LONG_W-1:0];
				ofe_pkg::REG_SYNC: sync_q <= wr_data[ofe_pkg::SYNC_W-1:0];
				default: ;
			endcase
		end
	end

	assign full  = q_full;
	assign q_wr  = push && !q_full;
	assign empty = !out_valid;

	ofe_front u_front (
		.device_id   (device_id),
		.unit_number (unit_number),
		.turn_off    (turn_off),
		.cmd         (new_cmd)
	);

	ofe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_cmd  (new_cmd),
		.rd      (q_rd),
		.rd_cmd  (head_cmd),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	ofe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.base_pulse (base_q),
		.long_ratio (long_q),
		.sync_ratio (sync_q),
		.q_cmd      (head_cmd),
		.q_empty    (q_empty),
		.q_rd       (q_rd),
		.pop        (pop),
		.out_valid  (out_valid),
		.high_time  (high_time),
		.low_time   (low_time),
		.fault      (fault),
		.last       (last)
	);

endmodule

// ----- hdl/ofe_front.sv -----
// Front end: validates one switch command and assembles its 48-bit frame.
// Depends on ofe_pkg.
`timescale 1ns / 1ps

module ofe_front (
	input  logic [ofe_pkg::ID_W-1:0]   device_id,
	input  logic [ofe_pkg::UNIT_W-1:0] unit_number,
	input  logic                       turn_off,
	output ofe_pkg::cmd_t              cmd
);

	logic id_bad;
	logic unit_bad;

	assign id_bad   = (device_id == '0) || (device_id > ofe_pkg::ID_MAX);
	assign unit_bad = (unit_number == '0) || (unit_number > ofe_pkg::UNIT_MAX);

	always_comb begin
		cmd.frame = {ofe_pkg::HDR_BYTE, 8'h00, device_id,
			ofe_pkg::device_code(unit_number, turn_off), ofe_pkg::FTR_BYTE};
		// id is checked before unit
		if (id_bad)
			cmd.fault = ofe_pkg::FAULT_ID;
		else if (unit_bad)
			cmd.fault = ofe_pkg::FAULT_UNIT;
		else
			cmd.fault = ofe_pkg::FAULT_NONE;
	end

endmodule

// ----- hdl/ofe_queue.sv -----
// Two-entry command queue between the front end and the pulse emitter.
// Depends on ofe_pkg.
`timescale 1ns / 1ps

module ofe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ofe_pkg::cmd_t wr_cmd,
	input  logic          rd,
	output ofe_pkg::cmd_t rd_cmd,
	output logic          q_full,
	output logic          q_empty
);

	ofe_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (wr && !rd)
				count_q <= count_q + 2'd1;
			else if (rd && !wr)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ----- hdl/ofe_back.sv -----
// Back end: shifts a queued frame out as one pulse pair per cycle into an
// output register while that register is free or popped. Depends on ofe_pkg.
`timescale 1ns / 1ps

module ofe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ofe_pkg::BASE_W-1:0]   base_pulse,
	input  logic [ofe_pkg::LONG_W-1:0]   long_ratio,
	input  logic [ofe_pkg::SYNC_W-1:0]   sync_ratio,
	input  ofe_pkg::cmd_t                q_cmd,
	input  logic                         q_empty,
	output logic                         q_rd,
	input  logic                         pop,
	output logic                         out_valid,
	output logic [ofe_pkg::TIME_W-1:0]   high_time,
	output logic [ofe_pkg::TIME_W-1:0]   low_time,
	output logic [1:0]                   fault,
	output logic                         last
);

	logic                              active_q;
	logic [ofe_pkg::FRAME_BITS-1:0]    frame_q;
	ofe_pkg::fault_t                   fault_q;
	logic [ofe_pkg::CNT_W-1:0]         cnt_q;
	logic                              out_valid_q;
	logic [ofe_pkg::TIME_W-1:0]        high_q;
	logic [ofe_pkg::TIME_W-1:0]        low_q;
	logic [1:0]                        fault_out_q;
	logic                              last_out_q;

	logic                       advance;
	logic                       emit;
	logic                       err_item;
	logic                       final_pair;
	logic                       finish;
	logic [ofe_pkg::TIME_W-1:0] base_t;
	logic [ofe_pkg::TIME_W-1:0] long_t;
	logic [ofe_pkg::TIME_W-1:0] sync_t;

	assign advance    = !out_valid_q || pop;
	assign emit       = active_q && advance;
	assign err_item   = (fault_q != ofe_pkg::FAULT_NONE);
	assign final_pair = (cnt_q == ofe_pkg::CNT_LAST);
	assign finish     = emit && (err_item || final_pair);
	// next command loads on the cycle the previous one's last pair goes out
	assign q_rd       = (!active_q || finish) && !q_empty;

	assign base_t = ofe_pkg::TIME_W'(base_pulse);
	assign long_t = base_t * ofe_pkg::TIME_W'(long_ratio);
	assign sync_t = base_t * ofe_pkg::TIME_W'(sync_ratio);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (finish) begin
				active_q <= 1'b0;
			end else if (emit) begin
				cnt_q <= cnt_q + ofe_pkg::CNT_W'(1);
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			frame_q <= q_cmd.frame;
			fault_q <= q_cmd.fault;
		end else if (emit) begin
			frame_q <= {frame_q[ofe_pkg::FRAME_BITS-2:0], 1'b0};
		end
		if (emit) begin
			fault_out_q <= fault_q;
			if (err_item) begin
				high_q     <= '0;
				low_q      <= '0;
				last_out_q <= 1'b1;
			end else begin
				high_q     <= frame_q[ofe_pkg::FRAME_BITS-1] ? long_t : base_t;
				low_q      <= final_pair ? sync_t : base_t;
				last_out_q <= final_pair;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign high_time = high_q;
	assign low_time  = low_q;
	assign fault     = fault_out_q;
	assign last      = last_out_q;

`ifndef NO_ASSERTIONS
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_empty)
		else $error("command loaded from an empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q <= ofe_pkg::CNT_LAST))
		else $error("pulse counter past frame end");

	a_fault_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (fault_out_q != ofe_pkg::FAULT_NONE)) |-> last_out_q)
		else $error("error item not marked last");

	a_emit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted pair not held in output register");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for ook_switch_frame_encoder_unit: commands in, pulse pairs out.
// Depends on ofe_pkg and the encoder RTL; the expected pulses come from its own frame builder.
`timescale 1ns / 1ps

typedef struct packed {
	logic [ofe_pkg::TIME_W-1:0] hi_time;
	logic [ofe_pkg::TIME_W-1:0] lo_time;
	ofe_pkg::fault_t            flt;
	logic                       is_last;
} pulse_t;

class pulse_scoreboard;

	pulse_t                      pending_pulses[$];
	logic [ofe_pkg::BASE_W-1:0]  base_len;
	logic [ofe_pkg::LONG_W-1:0]  long_mult;
	logic [ofe_pkg::SYNC_W-1:0]  sync_mult;
	int                          mismatches;

	function new();
		base_len   = ofe_pkg::BASE_RST;
		long_mult  = ofe_pkg::LONG_RST;
		sync_mult  = ofe_pkg::SYNC_RST;
		mismatches = 0;
	endfunction

	function void set_reg(logic [ofe_pkg::IDX_W-1:0] idx, logic [ofe_pkg::BASE_W-1:0] data);
		case (idx)
			ofe_pkg::REG_BASE: base_len  = data;
			ofe_pkg::REG_LONG: long_mult = data[ofe_pkg::LONG_W-1:0];
			ofe_pkg::REG_SYNC: sync_mult = data[ofe_pkg::SYNC_W-1:0];
			default: ;
		endcase
	endfunction

	function int pending();
		return pending_pulses.size();
	endfunction

	// One accepted command: either one fault item or a full frame of pulse pairs.
	function void note_cmd(logic [ofe_pkg::ID_W-1:0] id, logic [ofe_pkg::UNIT_W-1:0] unit,
		logic off);
		logic [ofe_pkg::FRAME_BITS-1:0] frame;
		logic [7:0]                     code;
		logic [31:0]                    one_len;
		logic [31:0]                    gap_len;
		pulse_t                         p;
		int                             grp;
		if (id == '0 || id > ofe_pkg::ID_MAX) begin
			p = '{hi_time: '0, lo_time: '0, flt: ofe_pkg::FAULT_ID, is_last: 1'b1};
			pending_pulses.push_back(p);
			return;
		end
		if (unit == '0 || unit > ofe_pkg::UNIT_MAX) begin
			p = '{hi_time: '0, lo_time: '0, flt: ofe_pkg::FAULT_UNIT, is_last: 1'b1};
			pending_pulses.push_back(p);
			return;
		end
		grp     = (int'(unit) - 1) / 5;
		code    = 8'(16 * grp + 2 * (int'(unit) - 5 * grp) - 1 + int'(off));
		frame   = {ofe_pkg::HDR_BYTE, 8'h00, id, code, ofe_pkg::FTR_BYTE};
		one_len = 32'(base_len) * 32'(long_mult);
		gap_len = 32'(base_len) * 32'(sync_mult);
		// msb of the frame goes out first
		for (int k = 0; k < ofe_pkg::FRAME_BITS; k++) begin
			p.hi_time = frame[ofe_pkg::FRAME_BITS-1-k] ? one_len[ofe_pkg::TIME_W-1:0]
				: ofe_pkg::TIME_W'(base_len);
			p.lo_time = (k == ofe_pkg::FRAME_BITS - 1) ? gap_len[ofe_pkg::TIME_W-1:0]
				: ofe_pkg::TIME_W'(base_len);
			p.flt     = ofe_pkg::FAULT_NONE;
			p.is_last = (k == ofe_pkg::FRAME_BITS - 1);
			pending_pulses.push_back(p);
		end
	endfunction

	function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t ns: mismatch on %s: expected %0d, got %0d", $realtime, what,
				exp_v, act_v);
	endfunction

	function void check_pulse(pulse_t got);
		pulse_t exp_p;
		if (pending_pulses.size() == 0) begin
			flag("unexpected item (nothing pending), high_time", 0, got.hi_time);
			return;
		end
		exp_p = pending_pulses.pop_front();
		if (got.hi_time !== exp_p.hi_time)
			flag("high_time", exp_p.hi_time, got.hi_time);
		if (got.lo_time !== exp_p.lo_time)
			flag("low_time", exp_p.lo_time, got.lo_time);
		if (got.flt !== exp_p.flt)
			flag("fault", exp_p.flt, got.flt);
		if (got.is_last !== exp_p.is_last)
			flag("last", exp_p.is_last, got.is_last);
	endfunction

endclass

module tb;

	localparam logic [ofe_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LONG_HOLD  = 200;
	localparam int SETTLE_CYC = 10;

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic [ofe_pkg::ID_W-1:0]     device_id;
	logic [ofe_pkg::UNIT_W-1:0]   unit_number;
	logic                         turn_off;
	logic                         empty;
	logic                         pop;
	logic [ofe_pkg::TIME_W-1:0]   high_time;
	logic [ofe_pkg::TIME_W-1:0]   low_time;
	logic [1:0]                   fault;
	logic                         last;
	logic                         wr_en;
	logic [ofe_pkg::IDX_W-1:0]    wr_index;
	logic [ofe_pkg::BASE_W-1:0]   wr_data;

	pulse_scoreboard          sb = new();
	pulse_t                   seen;
	bit                       calm;
	int                       hold_req;
	int                       hold_served;

	ook_switch_frame_encoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.device_id   (device_id),
		.unit_number (unit_number),
		.turn_off    (turn_off),
		.empty       (empty),
		.pop         (pop),
		.high_time   (high_time),
		.low_time    (low_time),
		.fault       (fault),
		.last        (last),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// both handshakes sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (push && !full)
				sb.note_cmd(device_id, unit_number, turn_off);
			if (pop && !empty) begin
				seen.hi_time = high_time;
				seen.lo_time = low_time;
				seen.flt     = ofe_pkg::fault_t'(fault);
				seen.is_last = last;
				sb.check_pulse(seen);
			end
		end
	end

	// receiver: short random stalls, plus a long hold on request
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != hold_served) begin
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served++;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_cmd(logic [ofe_pkg::ID_W-1:0] id, logic [ofe_pkg::UNIT_W-1:0] unit,
		logic off);
		push        <= 1'b1;
		device_id   <= id;
		unit_number <= unit;
		turn_off    <= off;
		do
			@(posedge clk);
		while (full !== 1'b0);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic send_random_cmds(int n);
		logic [ofe_pkg::ID_W-1:0]   id;
		logic [ofe_pkg::UNIT_W-1:0] unit;
		int                         kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			id   = ofe_pkg::ID_W'($urandom_range(1, 29999));
			unit = ofe_pkg::UNIT_W'($urandom_range(1, 19));
			case (kind)
				0: id = $urandom_range(0, 3) == 0 ? '0 : ofe_pkg::ID_W'($urandom_range(30000, 65535));
				1: begin
					id   = ofe_pkg::ID_W'($urandom_range(30000, 65535));
					unit = ofe_pkg::UNIT_W'($urandom_range(0, 31));
				end
				2: unit = $urandom_range(0, 2) == 0 ? '0 : ofe_pkg::UNIT_W'($urandom_range(20, 31));
				default: ;
			endcase
			send_cmd(id, unit, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_frames_out();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [ofe_pkg::IDX_W-1:0] idx, logic [ofe_pkg::BASE_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// drains the encoder first, then writes the registers
	task automatic program_timing(logic [ofe_pkg::BASE_W-1:0] base_v,
		logic [ofe_pkg::LONG_W-1:0] long_v, logic [ofe_pkg::SYNC_W-1:0] sync_v);
		wait_frames_out();
		write_reg(ofe_pkg::REG_BASE, base_v);
		write_reg(ofe_pkg::REG_LONG, ofe_pkg::BASE_W'(long_v));
		write_reg(REG_UNUSED, ofe_pkg::BASE_W'($urandom));
		write_reg(ofe_pkg::REG_SYNC, ofe_pkg::BASE_W'(sync_v));
		wr_en <= 1'b0;
	endtask

	initial begin
		arst_n      <= 1'b0;
		push        <= 1'b0;
		device_id   <= '0;
		unit_number <= '0;
		turn_off    <= 1'b0;
		wr_en       <= 1'b0;
		wr_index    <= '0;
		wr_data     <= '0;
		calm        = 1'b0;
		hold_req    = 0;
		hold_served = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items on reset timing
		send_cmd(16'd1, 5'd1, 1'b0);
		send_cmd(16'd29999, 5'd19, 1'b1);
		send_cmd(16'd0, 5'd5, 1'b0);
		send_cmd(16'd30000, 5'd5, 1'b1);
		send_cmd(16'hFFFF, 5'd31, 1'b1);    // bad id wins over bad unit
		send_cmd(16'd0, 5'd0, 1'b0);
		send_cmd(16'd1234, 5'd0, 1'b0);
		send_cmd(16'd1234, 5'd20, 1'b1);
		send_cmd(16'd29999, 5'd31, 1'b0);
		send_cmd(16'h5555, 5'd5, 1'b1);
		send_cmd(16'h2AAA, 5'd6, 1'b0);
		send_cmd(16'h5555, 5'd10, 1'b0);
		send_cmd(16'h2AAA, 5'd11, 1'b1);
		send_cmd(16'h752F, 5'd15, 1'b1);
		send_cmd(16'h0F0F, 5'd16, 1'b0);
		send_cmd(16'h7FFF, 5'd3, 1'b1);

		program_timing(16'hFFFF, 4'hF, 6'h3F);
		send_random_cmds(30);

		// long receiver hold: encoder fills up and pushes back
		program_timing(16'd1, 4'd1, 6'd1);
		hold_req++;
		send_random_cmds(30);

		program_timing(16'd0, 4'd0, 6'd0);
		send_random_cmds(15);

		program_timing(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)),
			6'($urandom_range(1, 63)));
		send_random_cmds(30);

		program_timing(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)),
			6'($urandom_range(1, 63)));
		send_random_cmds(20);

		calm = 1'b1;
		program_timing(ofe_pkg::BASE_RST, ofe_pkg::LONG_RST, ofe_pkg::SYNC_RST);
		send_random_cmds(25);

		wait_frames_out();
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- ook_switch_frame_encoder_unit.f -----
hdl/ofe_pkg.sv
hdl/ofe_front.sv
hdl/ofe_queue.sv
hdl/ofe_back.sv
hdl/ook_switch_frame_encoder_unit.sv
dv/tb.sv
